// File: rtl/bmhq_pkg.sv
// Shared types and constants for the max-priority queue.
package bmhq_pkg;

   localparam int DEF_CAPACITY  = 16;
   localparam int DEF_KEY_WIDTH = 16;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

// File: rtl/binary_max_heap_queue.sv
// A result item is registered in the cycle after its request item is accepted.
// One item per cycle while req_stall is low; the row of cells does the compare and shift for
// an insert or a remove in all cells at once, so the rate is set by the output register.
// Reset (synchronous, active high) clears the entry count and the output valid;
// the key cells are not cleared and are only read below the entry count.
// Ordering of equal keys inside the row is not visible at the ports.
module binary_max_heap_queue import bmhq_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
   parameter int FILL_WIDTH = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [KEY_WIDTH-1:0]  req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KEY_WIDTH-1:0]  rsp_top_key,
   output logic [1:0]            rsp_status,
   output logic [FILL_WIDTH-1:0] rsp_fill
);

   localparam logic [FILL_WIDTH-1:0] FULL_COUNT = FILL_WIDTH'(CAPACITY);

   logic [FILL_WIDTH-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0]  top_key_ff, top_key_in;
   status_type            status_ff, status_in;
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   cell_ctrl_type         ctrl;

   logic [CAPACITY-1:0]   occ;
   logic [CAPACITY-1:0]   gt;
   logic [KEY_WIDTH-1:0]  entries [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);

   assign ctrl.ins = accept && (action_type'(req_action) == ACT_INSERT) && !full;
   assign ctrl.rem = accept && (action_type'(req_action) == ACT_REMOVE) && !empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [FILL_WIDTH-1:0] IDX = FILL_WIDTH'(i);
      logic                 up_gt;
      logic [KEY_WIDTH-1:0] up_entry;
      logic [KEY_WIDTH-1:0] down_entry;

      assign occ[i] = (IDX < count_ff);

      if (i == 0) begin : g_first
         assign up_gt    = 1'b0;
         assign up_entry = req_key;
      end else begin : g_rest
         assign up_gt    = gt[i-1];
         assign up_entry = entries[i-1];
      end

      // last cell pulls its own value; it leaves the occupied range on a remove
      if (i == CAPACITY - 1) begin : g_last
         assign down_entry = entries[i];
      end else begin : g_inner
         assign down_entry = entries[i+1];
      end

      bmhq_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key        (req_key),
         .occupied   (occ[i]),
         .up_gt      (up_gt),
         .up_entry   (up_entry),
         .down_entry (down_entry),
         .gt         (gt[i]),
         .entry      (entries[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + FILL_WIDTH'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - FILL_WIDTH'(1);
      end

      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

      top_key_in = top_key_ff;
      status_in  = status_ff;
      fill_in    = fill_ff;
      if (accept) begin
         top_key_in = ctrl.rem ? entries[0] : '0;
         fill_in    = count_in;
         if (action_type'(req_action) == ACT_INSERT) begin
            status_in = full ? STATUS_FULL : STATUS_OK;
         end else begin
            status_in = empty ? STATUS_EMPTY : STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_key_ff <= top_key_in;
      status_ff  <= status_in;
      fill_ff    <= fill_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_top_key = top_key_ff;
   assign rsp_status  = status_ff;
   assign rsp_fill    = fill_ff;

endmodule

// File: rtl/bmhq_cell.sv
// One storage cell of the sorted queue row: holds one key, shifts with its neighbors.
module bmhq_cell import bmhq_pkg::*; #(
   parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [KEY_WIDTH-1:0] key,
   input  logic                 occupied,
   input  logic                 up_gt,
   input  logic [KEY_WIDTH-1:0] up_entry,
   input  logic [KEY_WIDTH-1:0] down_entry,
   output logic                 gt,
   output logic [KEY_WIDTH-1:0] entry
);

   logic [KEY_WIDTH-1:0] entry_ff;
   logic [KEY_WIDTH-1:0] entry_in;

   // row is sorted descending, so gt is a thermometer: 0s above, 1s below
   assign gt    = !occupied || ($signed(key) > $signed(entry_ff));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (gt) begin
            entry_in = up_gt ? up_entry : key;
         end
      end else if (ctrl.rem) begin
         entry_in = down_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/bmhq_checker.sv
// Port-level checks for the max-priority queue, bound to the top level.
module bmhq_checker import bmhq_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
   parameter int FILL_WIDTH = $clog2(CAPACITY + 1)
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [KEY_WIDTH-1:0]  rsp_top_key,
   input logic [1:0]            rsp_status,
   input logic [FILL_WIDTH-1:0] rsp_fill
);

   localparam logic [FILL_WIDTH-1:0] FULL_COUNT = FILL_WIDTH'(CAPACITY);

   // a stalled result item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_key) &&
                                 $stable(rsp_status) && $stable(rsp_fill))
      else $error("stalled result item changed");

   // every accepted request item yields a result item next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill <= FULL_COUNT)
      else $error("fill beyond capacity");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_fill == FULL_COUNT &&
                                                 rsp_top_key == '0)
      else $error("full status with wrong fill or key");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_fill == '0 &&
                                                  rsp_top_key == '0)
      else $error("empty status with wrong fill or key");

endmodule

bind binary_max_heap_queue bmhq_checker #(
   .CAPACITY   (CAPACITY),
   .KEY_WIDTH  (KEY_WIDTH),
   .FILL_WIDTH (FILL_WIDTH)
) u_bmhq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_top_key (rsp_top_key),
   .rsp_status  (rsp_status),
   .rsp_fill    (rsp_fill)
);
